### hw/rtl/r2b_pkg.sv
// ----------------------------------------------------------------------------
// r2b_pkg
// shared widths, register indexes, queue command and geometry types, and the
// byte table of the bmp file header
// ----------------------------------------------------------------------------
`default_nettype none

package r2b_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CAP_W     = 32;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFF_W     = 26;
  localparam int unsigned STRIDE_W  = 15;
  localparam int unsigned IMG_W     = 28;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CMD_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST    = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [CAP_W-1:0] CAPACITY_RST = 32'hFFFF_FFFF;

  localparam int unsigned HDR_BYTES = 54;
  localparam logic [CNT_W-1:0] HDR_LAST = 6'd53;

  // header field positions
  localparam logic [CNT_W-1:0] HDR_OFF_MAGIC  = 6'd0;
  localparam logic [CNT_W-1:0] HDR_OFF_SIZE   = 6'd2;
  localparam logic [CNT_W-1:0] HDR_OFF_DATA   = 6'd10;
  localparam logic [CNT_W-1:0] HDR_OFF_INFO   = 6'd14;
  localparam logic [CNT_W-1:0] HDR_OFF_WIDTH  = 6'd18;
  localparam logic [CNT_W-1:0] HDR_OFF_HEIGHT = 6'd22;
  localparam logic [CNT_W-1:0] HDR_OFF_PLANES = 6'd26;
  localparam logic [CNT_W-1:0] HDR_OFF_BPP    = 6'd28;
  localparam logic [CNT_W-1:0] HDR_OFF_IMG    = 6'd34;

  localparam logic [31:0] BMP_MAGIC  = 32'h0000_4D42;
  localparam logic [31:0] INFO_SIZE  = 32'd40;
  localparam logic [31:0] PLANES     = 32'd1;
  localparam logic [31:0] BITS_PIXEL = 32'd24;

  typedef struct packed {
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [CAP_W-1:0]    cap;
    logic [STRIDE_W-1:0] rb;       // bytes of pixel data in one row
    logic [STRIDE_W-1:0] stride;
    logic [IMG_W-1:0]    img;
    logic [OFF_W-1:0]    lastrow;  // (h - 1) * stride
    logic                bad;      // width or height out of range
  } geom_t;

  typedef struct packed {
    logic             reject;
    logic             hdr;
    logic             frame_end;
    logic [PIX_W-1:0] pixel;
    logic [OFF_W-1:0] pos;
    logic [OFF_W-1:0] pad_base;
    logic [1:0]       pad;
  } cmd_t;

  // byte of a little-endian word that sits at position at
  function automatic logic [BYTE_W-1:0] le_pick(input logic [31:0] v,
                                                input logic [CNT_W-1:0] idx,
                                                input logic [CNT_W-1:0] at);
    logic [CNT_W-1:0] rel;
    logic [BYTE_W-1:0] b;
    rel = idx - at;
    b = '0;
    if (idx >= at && rel < 6'd4) begin
      b = v[{rel[1:0], 3'b000} +: BYTE_W];
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [CNT_W-1:0] idx,
                                                 input geom_t g);
    logic [31:0] total;
    logic [31:0] w32;
    logic [31:0] h32;
    logic [31:0] img32;
    total = {{(32-IMG_W){1'b0}}, g.img} + HDR_BYTES;
    w32   = {{(32-DIM_W){1'b0}}, g.w};
    h32   = {{(32-DIM_W){1'b0}}, g.h};
    img32 = {{(32-IMG_W){1'b0}}, g.img};
    // fields that are narrower than four bytes are zero above, so or-ing is safe
    return le_pick(BMP_MAGIC, idx, HDR_OFF_MAGIC)
         | le_pick(total, idx, HDR_OFF_SIZE)
         | le_pick(32'(HDR_BYTES), idx, HDR_OFF_DATA)
         | le_pick(INFO_SIZE, idx, HDR_OFF_INFO)
         | le_pick(w32, idx, HDR_OFF_WIDTH)
         | le_pick(h32, idx, HDR_OFF_HEIGHT)
         | le_pick(PLANES, idx, HDR_OFF_PLANES)
         | le_pick(BITS_PIXEL, idx, HDR_OFF_BPP)
         | le_pick(img32, idx, HDR_OFF_IMG);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/r2b_geom.sv
// ----------------------------------------------------------------------------
// r2b_geom
// configuration registers and the frame geometry derived from them
// ----------------------------------------------------------------------------
`default_nettype none

module r2b_geom #(
  parameter int unsigned MAX_WIDTH  = r2b_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = r2b_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [r2b_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [r2b_pkg::CAP_W-1:0]      cfg_data_i,
  output r2b_pkg::geom_t                      geom_o
);

  logic [r2b_pkg::DIM_W-1:0]    w_q, h_q;
  logic [r2b_pkg::CAP_W-1:0]    cap_q;
  logic [r2b_pkg::STRIDE_W-1:0] rb_c, stride_c, rb_q, stride_q;
  logic [r2b_pkg::DIM_W-1:0]    hm1_c;
  logic [r2b_pkg::IMG_W-1:0]    img_c, lastrow_c, img_q;
  logic [r2b_pkg::OFF_W-1:0]    lastrow_q;
  logic                         bad_c, bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= r2b_pkg::WIDTH_RST;
      h_q   <= r2b_pkg::HEIGHT_RST;
      cap_q <= r2b_pkg::CAPACITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        r2b_pkg::CFG_WIDTH:    w_q   <= cfg_data_i[r2b_pkg::DIM_W-1:0];
        r2b_pkg::CFG_HEIGHT:   h_q   <= cfg_data_i[r2b_pkg::DIM_W-1:0];
        r2b_pkg::CFG_CAPACITY: cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rb_c     = {2'b00, w_q} + {1'b0, w_q, 1'b0};
    stride_c = (rb_c + 15'd3) & ~15'd3;
    hm1_c    = h_q - 13'd1;
    img_c    = {{(r2b_pkg::IMG_W-r2b_pkg::STRIDE_W){1'b0}}, stride_c}
             * {{(r2b_pkg::IMG_W-r2b_pkg::DIM_W){1'b0}}, h_q};
    lastrow_c = {{(r2b_pkg::IMG_W-r2b_pkg::STRIDE_W){1'b0}}, stride_c}
              * {{(r2b_pkg::IMG_W-r2b_pkg::DIM_W){1'b0}}, hm1_c};
    bad_c = (w_q == '0) || (h_q == '0)
         || ({{(32-r2b_pkg::DIM_W){1'b0}}, w_q} > 32'(MAX_WIDTH))
         || ({{(32-r2b_pkg::DIM_W){1'b0}}, h_q} > 32'(MAX_HEIGHT));
  end

  // derived values are registered from the registers and follow them in the next cycle
  always_ff @(posedge clk_i) begin
    rb_q      <= rb_c;
    stride_q  <= stride_c;
    img_q     <= img_c;
    lastrow_q <= lastrow_c[r2b_pkg::OFF_W-1:0];
    bad_q     <= bad_c;
  end

  always_comb begin
    geom_o.w       = w_q;
    geom_o.h       = h_q;
    geom_o.cap     = cap_q;
    geom_o.rb      = rb_q;
    geom_o.stride  = stride_q;
    geom_o.img     = img_q;
    geom_o.lastrow = lastrow_q;
    geom_o.bad     = bad_q;
  end

endmodule

`default_nettype wire

### hw/rtl/r2b_front.sv
// ----------------------------------------------------------------------------
// r2b_front
// takes pixels, tracks row and column, and turns each pixel into a command
// ----------------------------------------------------------------------------
`default_nettype none

module r2b_front #(
  parameter int unsigned MAX_WIDTH  = r2b_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = r2b_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [r2b_pkg::PIX_W-1:0]  pixel_i,
  input  wire r2b_pkg::geom_t             geom_i,
  input  wire logic                       full_i,
  output logic                            push_o,
  output r2b_pkg::cmd_t                   cmd_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned OW = r2b_pkg::OFF_W;

  logic                      fv_q;
  logic [r2b_pkg::PIX_W-1:0] px_q;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [OW-1:0]             rbase_q, rbase_d;

  logic          reject, hdr, row_end, frame_end;
  logic [31:0]   total;
  logic [OW-1:0] first, base, col_ext, col3;

  assign in_stall_o = fv_q & full_i;
  assign push_o     = fv_q & ~full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (!in_stall_o) begin
      fv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      px_q <= pixel_i;
    end
  end

  always_comb begin
    total  = {{(32-r2b_pkg::IMG_W){1'b0}}, geom_i.img} + r2b_pkg::HDR_BYTES;
    reject = geom_i.bad || (total > geom_i.cap);
    hdr    = (col_q == '0) && (row_q == '0);
    first  = geom_i.lastrow + OW'(r2b_pkg::HDR_BYTES);
    base   = hdr ? first : rbase_q;
    col_ext = {{(OW-CW){1'b0}}, col_q};
    col3   = col_ext + {col_ext[OW-2:0], 1'b0};
    row_end = ({{(32-CW){1'b0}}, col_q} + 32'd1)
           >= {{(32-r2b_pkg::DIM_W){1'b0}}, geom_i.w};
    frame_end = row_end && (({{(32-RW){1'b0}}, row_q} + 32'd1)
           >= {{(32-r2b_pkg::DIM_W){1'b0}}, geom_i.h});

    cmd_o.reject    = reject;
    cmd_o.hdr       = hdr;
    cmd_o.frame_end = frame_end;
    cmd_o.pixel     = px_q;
    cmd_o.pos       = base + col3;
    cmd_o.pad_base  = base + {{(OW-r2b_pkg::STRIDE_W){1'b0}}, geom_i.rb};
    // zero bytes that bring 3 * width up to a multiple of four
    cmd_o.pad       = row_end ? (2'd0 - geom_i.rb[1:0]) : 2'd0;

    col_d   = col_q + CW'(1);
    row_d   = row_q;
    rbase_d = base;
    if (reject) begin
      col_d   = '0;
      row_d   = '0;
      rbase_d = '0;
    end else if (row_end) begin
      col_d = '0;
      if (frame_end) begin
        row_d   = '0;
        rbase_d = '0;
      end else begin
        row_d   = row_q + RW'(1);
        rbase_d = base - {{(OW-r2b_pkg::STRIDE_W){1'b0}}, geom_i.stride};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      rbase_q <= '0;
    end else if (push_o) begin
      col_q   <= col_d;
      row_q   <= row_d;
      rbase_q <= rbase_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/r2b_cmd_fifo.sv
// ----------------------------------------------------------------------------
// r2b_cmd_fifo
// short command queue between the front and the byte sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module r2b_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire r2b_pkg::cmd_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output r2b_pkg::cmd_t      head_o
);

  localparam int unsigned DEPTH = r2b_pkg::CMD_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  r2b_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] num_q;
  logic          do_push, do_pop;

  assign full_o  = (num_q == NW'(DEPTH));
  assign empty_o = (num_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        num_q <= num_q + NW'(1);
      end else if (do_pop && !do_push) begin
        num_q <= num_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/r2b_back.sv
// ----------------------------------------------------------------------------
// r2b_back
// byte sequencer: header, pixel and padding bytes, or a status beat for a
// rejected command, from the queue head, one beat per cycle while the queue
// holds a command and the output is not stalled, into the output register
`default_nettype none

module r2b_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire r2b_pkg::cmd_t                head_i,
  input  wire logic                         empty_i,
  output logic                              pop_o,
  input  wire r2b_pkg::geom_t               geom_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [r2b_pkg::BYTE_W-1:0]        byte_value_o,
  output logic [r2b_pkg::OFF_W-1:0]         byte_offset_o,
  output logic                              last_of_run_o,
  output logic                              end_of_frame_o,
  output logic                              status_o
);

  localparam logic [1:0] PH_REJ = 2'd0;
  localparam logic [1:0] PH_HDR = 2'd1;
  localparam logic [1:0] PH_PIX = 2'd2;
  localparam logic [1:0] PH_PAD = 2'd3;

  localparam int unsigned OW = r2b_pkg::OFF_W;
  localparam int unsigned NW = r2b_pkg::CNT_W;

  logic          started_q;
  logic [1:0]    ph_q, ph, ph_n;
  logic [NW-1:0] cnt_q, cnt, cnt_n;
  logic          adv, last, st;
  logic [r2b_pkg::BYTE_W-1:0] val;
  logic [OW-1:0] off, cnt_ext;

  logic                       out_valid_q;
  logic [r2b_pkg::BYTE_W-1:0] val_q;
  logic [OW-1:0]              off_q;
  logic                       last_q, eof_q, st_q;

  always_comb begin
    adv = !empty_i && (!out_valid_q || !out_stall_i);
    if (started_q) begin
      ph  = ph_q;
      cnt = cnt_q;
    end else begin
      ph  = head_i.reject ? PH_REJ : (head_i.hdr ? PH_HDR : PH_PIX);
      cnt = '0;
    end
    cnt_ext = {{(OW-NW){1'b0}}, cnt};

    val   = '0;
    off   = '0;
    st    = 1'b0;
    last  = 1'b0;
    ph_n  = ph;
    cnt_n = cnt + NW'(1);
    case (ph)
      PH_REJ: begin
        st   = 1'b1;
        last = 1'b1;
      end
      PH_HDR: begin
        val = r2b_pkg::hdr_byte(cnt, geom_i);
        off = cnt_ext;
        if (cnt == r2b_pkg::HDR_LAST) begin
          ph_n  = PH_PIX;
          cnt_n = '0;
        end
      end
      PH_PIX: begin
        off = head_i.pos + cnt_ext;
        case (cnt[1:0])
          2'd0:    val = {head_i.pixel[4:0], 3'b000};
          2'd1:    val = {head_i.pixel[10:5], 2'b00};
          default: val = {head_i.pixel[15:11], 3'b000};
        endcase
        if (cnt[1:0] == 2'd2) begin
          if (head_i.pad == 2'd0) begin
            last = 1'b1;
          end else begin
            ph_n  = PH_PAD;
            cnt_n = '0;
          end
        end
      end
      PH_PAD: begin
        off  = head_i.pad_base + cnt_ext;
        last = (cnt[1:0] == head_i.pad - 2'd1);
      end
      default: ;
    endcase
  end

  assign pop_o = adv & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      ph_q      <= PH_REJ;
      cnt_q     <= '0;
    end else if (adv) begin
      started_q <= ~last;
      ph_q      <= ph_n;
      cnt_q     <= cnt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      val_q  <= val;
      off_q  <= off;
      st_q   <= st;
      last_q <= last;
      eof_q  <= last & head_i.frame_end & ~head_i.reject;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_value_o   = val_q;
  assign byte_offset_o  = off_q;
  assign last_of_run_o  = last_q;
  assign end_of_frame_o = eof_q;
  assign status_o       = st_q;

endmodule

`default_nettype wire

### hw/rtl/rgb565_to_bmp24_writer.sv
// path: an accepted pixel goes through the front's input register, the command
//   queue and the output register; one output beat per cycle while the queue
//   holds a command and the output is not stalled; three bytes per pixel, plus
//   54 header bytes before a frame's first pixel, up to 3 padding bytes at row end
// reset: position counters zero, registers 640 / 480 / all ones, queue empty
// ----------------------------------------------------------------------------
// rgb565_to_bmp24_writer
// rgb565 pixels in, addressed bytes of a 24-bit bmp file out
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_to_bmp24_writer #(
  parameter int unsigned MAX_WIDTH  = r2b_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = r2b_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [r2b_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [r2b_pkg::CAP_W-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [r2b_pkg::PIX_W-1:0]      pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [r2b_pkg::BYTE_W-1:0]          byte_value_o,
  output logic [r2b_pkg::OFF_W-1:0]           byte_offset_o,
  output logic                                last_of_run_o,
  output logic                                end_of_frame_o,
  output logic                                status_o
);

  r2b_pkg::geom_t geom;
  r2b_pkg::cmd_t  cmd, head;
  logic           push, full, pop, empty;

  r2b_geom #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  r2b_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .geom_i     (geom),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  r2b_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  r2b_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .geom_i         (geom),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_value_o   (byte_value_o),
    .byte_offset_o  (byte_offset_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

### test/tb_rgb565_to_bmp24_writer.sv
// ----------------------------------------------------------------------------
// tb_rgb565_to_bmp24_writer
// drives rgb565 pixels into the bmp writer under several frame geometries and
// buffer capacities, predicts every addressed file byte (header, pixel data,
// row padding, rejects) and compares each output beat in order
// ----------------------------------------------------------------------------
module tb_rgb565_to_bmp24_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import r2b_pkg::*;

  localparam int unsigned RAND_ITEMS     = 100;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned END_TAIL       = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic [15:0] SIG_BM  = 16'h4D42;
  localparam logic [31:0] DIB_LEN = 32'd40;
  localparam logic [7:0]  BPP24   = 8'd24;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [OFF_W-1:0]  offset;
    logic              last;
    logic              eof;
    logic              rejected;
  } bmp_byte_t;

  class bmp_byte_tracker;
    bmp_byte_t         expected_bytes[$];
    int unsigned       mismatches;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CAP_W-1:0]  capacity;
    logic [11:0]       col;
    logic [11:0]       row;
    logic [OFF_W-1:0]  row_base;

    function new();
      mismatches = 0;
      width      = 13'd640;
      height     = 13'd480;
      capacity   = 32'hFFFF_FFFF;
      col        = '0;
      row        = '0;
      row_base   = '0;
    endfunction

    // size of the whole file, zero when the geometry is out of range
    static function longint unsigned file_bytes(int unsigned w, int unsigned h);
      int unsigned stride;
      if (w == 0 || h == 0 || w > MAX_WIDTH_DEF || h > MAX_HEIGHT_DEF) begin
        return 0;
      end
      stride = (w * 3 + 3) & ~32'd3;
      return 64'(HDR_BYTES) + 64'(stride) * 64'(h);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
      case (idx)
        CFG_WIDTH: begin
          width = data[DIM_W-1:0];
        end
        CFG_HEIGHT: begin
          height = data[DIM_W-1:0];
        end
        CFG_CAPACITY: begin
          capacity = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void add_byte(logic [BYTE_W-1:0] v, logic [OFF_W-1:0] off);
      expected_bytes.push_back('{value: v, offset: off, last: 1'b0, eof: 1'b0,
                                 rejected: 1'b0});
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      longint unsigned total;
      int unsigned     rb;
      int unsigned     stride;
      int unsigned     img;
      int unsigned     p;
      int unsigned     i;
      logic [OFF_W-1:0] pos;
      logic [31:0]     total32;
      logic [31:0]     w32;
      logic [31:0]     h32;
      logic [31:0]     img32;
      logic [31:0]     hdr_len;
      logic [7:0]      hdr [0:53];
      bit              done;
      done  = 1'b0;
      total = file_bytes(width, height);
      if (total == 0 || total > 64'(capacity)) begin
        expected_bytes.push_back('{value: '0, offset: '0, last: 1'b1, eof: 1'b0,
                                   rejected: 1'b1});
        col      = '0;
        row      = '0;
        row_base = '0;
        return;
      end
      rb     = 32'(width) * 3;
      stride = (rb + 3) & ~32'd3;
      img    = stride * 32'(height);
      if (col == 0 && row == 0) begin
        total32 = 32'(total);
        w32     = 32'(width);
        h32     = 32'(height);
        img32   = img;
        hdr_len = 32'(HDR_BYTES);
        for (i = 0; i < HDR_BYTES; i++) begin
          hdr[i] = 8'h00;
        end
        hdr[0]  = SIG_BM[7:0];
        hdr[1]  = SIG_BM[15:8];
        hdr[26] = 8'd1;
        hdr[28] = BPP24;
        for (i = 0; i < 4; i++) begin
          hdr[2 + i]  = total32[8 * i +: 8];
          hdr[10 + i] = hdr_len[8 * i +: 8];
          hdr[14 + i] = DIB_LEN[8 * i +: 8];
          hdr[18 + i] = w32[8 * i +: 8];
          hdr[22 + i] = h32[8 * i +: 8];
          hdr[34 + i] = img32[8 * i +: 8];
        end
        for (i = 0; i < HDR_BYTES; i++) begin
          add_byte(hdr[i], OFF_W'(i));
        end
        // rows are stored bottom-up, so the first source row goes last
        row_base = OFF_W'(HDR_BYTES + (32'(height) - 1) * stride);
      end
      pos = row_base + OFF_W'(int'(col) * 3);
      add_byte({px[4:0], 3'b000}, pos);
      add_byte({px[10:5], 2'b00}, pos + 1'b1);
      add_byte({px[15:11], 3'b000}, pos + 2'd2);
      if (int'(col) + 1 >= int'(width)) begin
        for (p = rb; p < stride; p++) begin
          add_byte(8'h00, row_base + OFF_W'(p));
        end
        col = '0;
        if (int'(row) + 1 >= int'(height)) begin
          row      = '0;
          row_base = '0;
          done     = 1'b1;
        end else begin
          row      = row + 1'b1;
          row_base = row_base - OFF_W'(stride);
        end
      end else begin
        col = col + 1'b1;
      end
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      if (done) begin
        expected_bytes[expected_bytes.size() - 1].eof = 1'b1;
      end
    endfunction

    function void check_byte(bmp_byte_t got);
      bmp_byte_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat value %0h offset %0h last %0b eof %0b status %0b",
                 $time, got.value, got.offset, got.last, got.eof, got.rejected);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: expected value %0h offset %0h last %0b eof %0b status %0b",
                 $time, want.value, want.offset, want.last, want.eof, want.rejected);
        $display("%0t: actual   value %0h offset %0h last %0b eof %0b status %0b",
                 $time, got.value, got.offset, got.last, got.eof, got.rejected);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    byte_value;
  logic [OFF_W-1:0]     byte_offset;
  logic                 last_of_run;
  logic                 end_of_frame;
  logic                 status;

  bmp_byte_tracker  sb;
  logic [PIX_W-1:0] pix_q[$];
  bit               tx_burst;
  bit               rx_burst;
  bit               hold_off_req;

  rgb565_to_bmp24_writer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pixel_i        (pixel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .byte_value_o   (byte_value),
    .byte_offset_o  (byte_offset),
    .last_of_run_o  (last_of_run),
    .end_of_frame_o (end_of_frame),
    .status_o       (status)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_write(CFG_WIDTH, 32'(w));
    cfg_write(CFG_HEIGHT, 32'(h));
    cfg_write(CFG_CAPACITY, cap);
  endtask

  task automatic send_pixels();
    int unsigned gap;
    while (pix_q.size() != 0) begin
      if ($urandom_range(0, 23) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid <= 1'b1;
      pixel    <= pix_q[0];
      @(posedge clk_i);
      while (in_stall) @(posedge clk_i);
      sb.note_pixel(pix_q.pop_front());
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain_bytes();
    int unsigned gap;
    bmp_byte_t   got;
    forever begin
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 16);
      if (hold_off_req) begin
        // long hold so the block backs up into its input
        hold_off_req = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      got.value    = byte_value;
      got.offset   = byte_offset;
      got.last     = last_of_run;
      got.eof      = end_of_frame;
      got.rejected = status;
      sb.check_byte(got);
    end
  endtask

  initial begin : receiver
    out_stall <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    drain_bytes();
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned     w;
    int unsigned     h;
    int unsigned     n;
    int unsigned     kind;
    int unsigned     rand_sent;
    logic [CAP_W-1:0] cap;
    longint unsigned fb;
    sb           = new();
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    hold_off_req = 1'b0;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    pixel     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry, leaves the frame open in its first row
    pix_q.push_back(16'hFFFF);
    send_pixels();

    // shrink the frame mid-row, then one full 1x2 frame
    configure(1, 2, '1);
    cfg_write(CFG_SPARE, $urandom());
    pix_q.push_back(16'h0000);
    pix_q.push_back(16'hF800);
    pix_q.push_back(16'h07E0);
    pix_q.push_back(16'h001F);
    send_pixels();

    // geometry rejects
    configure(0, 2, '1);
    pix_q.push_back(16'h1234);
    send_pixels();
    configure(3, 0, '1);
    pix_q.push_back(16'hA5A5);
    send_pixels();
    configure(4097, 1, '1);
    pix_q.push_back(16'h5A5A);
    send_pixels();
    configure(1, 8191, '1);
    pix_q.push_back(16'hFFFF);
    send_pixels();

    // capacity: none, one byte short, exact fit
    configure(2, 1, '0);
    pix_q.push_back(16'h8001);
    send_pixels();
    configure(2, 1, 32'd61);
    pix_q.push_back(16'h7FFE);
    send_pixels();
    configure(2, 1, 32'd62);
    pix_q.push_back(16'hFFFF);
    pix_q.push_back(16'h0000);
    send_pixels();

    // largest frame, then cut it short with a narrow single row
    configure(4096, 4096, '1);
    pix_q.push_back(16'hFFFF);
    pix_q.push_back(16'h0000);
    send_pixels();
    configure(3, 1, '1);
    pix_q.push_back(pick_pixel());
    send_pixels();

    // grow the height mid-frame until the row base wraps below zero
    configure(2, 1, '1);
    pix_q.push_back(pick_pixel());
    send_pixels();
    configure(1, 4096, '1);
    repeat (15) pix_q.push_back(pick_pixel());
    send_pixels();
    // row already past height - 1
    configure(1, 1, '1);
    pix_q.push_back(pick_pixel());
    send_pixels();

    hold_off_req = 1'b1;
    configure(4, 3, '1);
    repeat (24) pix_q.push_back(pick_pixel());
    rand_sent = 24;
    send_pixels();

    while (rand_sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      w    = $urandom_range(1, 5);
      h    = $urandom_range(1, 3);
      cap  = '1;
      n    = w * h * $urandom_range(1, 2);
      if (kind == 5) begin
        // partial frames, the next phase changes geometry mid-frame
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 4);
        n = $urandom_range(1, 7);
      end else if (kind == 6) begin
        fb  = bmp_byte_tracker::file_bytes(w, h);
        cap = 32'(fb) + 32'($urandom_range(0, 2)) - 32'd1;
        n   = w * h;
      end else if (kind == 7) begin
        case ($urandom_range(0, 3))
          0: w = 0;
          1: h = 0;
          2: w = $urandom_range(4097, 8191);
          default: h = $urandom_range(4097, 8191);
        endcase
        n = $urandom_range(1, 3);
      end else if (kind == 8) begin
        w = $urandom_range(1, 4096);
        h = $urandom_range(1, 4096);
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 1) == 1) cap = $urandom();
      end else if (kind == 9) begin
        cap = $urandom();
        n   = w * h;
      end
      configure(w, h, cap);
      repeat (n) pix_q.push_back(pick_pixel());
      rand_sent += n;
      send_pixels();
    end

    wait_drained();
    repeat (END_TAIL) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### rgb565_to_bmp24_writer.f
hw/rtl/r2b_pkg.sv
hw/rtl/r2b_geom.sv
hw/rtl/r2b_front.sv
hw/rtl/r2b_cmd_fifo.sv
hw/rtl/r2b_back.sv
hw/rtl/rgb565_to_bmp24_writer.sv
test/tb_rgb565_to_bmp24_writer.sv
